@@ hw/rtl/ocmvn_pkg.sv @@
// ----------------------------------------------------------------------------
// Online CMVN package
// Shared types, codes and constants of the online mean/variance normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package ocmvn_pkg;

  localparam int unsigned DimMax  = 64;
  localparam int unsigned DimW    = $clog2(DimMax);
  localparam int unsigned EntryW  = 64;   // {mean, variance}
  localparam int unsigned OperW   = 51;   // widest dividend in the step unit
  localparam int unsigned RemW    = 28;
  localparam int unsigned DenW    = 25;
  localparam int unsigned RootW   = 24;
  localparam int unsigned CntW    = 6;

  // Step counts of the shared unit for each job.
  localparam logic [CntW-1:0] StepsRoot = 6'd24;
  localparam logic [CntW-1:0] StepsNorm = 6'd51;

  // Last step of the shift-and-add division by ten.
  localparam logic [2:0] TenthLastPh = 3'd6;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_LOAD   = 2'd1,
    OP_START  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MODE_NEVER = 2'd0,
    MODE_ONCE  = 2'd1,
    MODE_EVERY = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_VEC_SIZE   = 2'd0,
    REG_RESET_MODE = 2'd1,
    REG_NONE2      = 2'd2,
    REG_NONE3      = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_MUL, S_VAR, S_DIVV, S_MEAN, S_DIVM, S_UPD,
    S_SQRT, S_DEN, S_DIVQ, S_FIN, S_CP_RD, S_CP_WR, S_OUT
  } state_e;

  typedef struct packed {
    logic                  start;
    logic                  root;      // square root instead of division
    logic [CntW-1:0]       steps;
    logic [OperW-1:0]      operand;   // left aligned
    logic [DenW-1:0]       divisor;
  } step_cmd_t;

  typedef struct packed {
    logic busy;
  } step_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/ocmvn_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ocmvn_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ hw/rtl/ocmvn_step.sv @@
// ----------------------------------------------------------------------------
// Shared step unit
// Radix-2 restoring divider and digit-by-digit square root that share one
// compare-and-subtract stage, one quotient or root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ocmvn_step (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  ocmvn_pkg::step_cmd_t       cmd_i,
  output ocmvn_pkg::step_sts_t       sts_o,
  output logic [ocmvn_pkg::OperW-1:0] quot_o,
  output logic [ocmvn_pkg::RootW-1:0] root_o
);
  import ocmvn_pkg::*;

  logic            busy_q, busy_d;
  logic            root_q, root_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [OperW-1:0] dq_q, dq_d;
  logic [RootW-1:0] res_q, res_d;
  logic [DenW-1:0]  den_q, den_d;

  logic [RemW-1:0] op_a, op_b;
  logic [RemW:0]   diff;
  logic            ge;

  // The one shared compare-and-subtract.
  always_comb begin
    if (root_q) begin
      op_a = {rem_q[RemW-3:0], dq_q[OperW-1 -: 2]};
      op_b = {2'b00, res_q, 2'b01};
    end else begin
      op_a = {rem_q[RemW-2:0], dq_q[OperW-1]};
      op_b = {{(RemW-DenW){1'b0}}, den_q};
    end
    diff = {1'b0, op_a} - {1'b0, op_b};
    ge   = ~diff[RemW];
  end

  always_comb begin
    busy_d = busy_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dq_d   = dq_q;
    res_d  = res_q;
    den_d  = den_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      root_d = cmd_i.root;
      cnt_d  = cmd_i.steps;
      rem_d  = '0;
      dq_d   = cmd_i.operand;
      res_d  = '0;
      den_d  = cmd_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? diff[RemW-1:0] : op_a;
      if (root_q) begin
        dq_d  = {dq_q[OperW-3:0], 2'b00};
        res_d = {res_q[RootW-2:0], ge};
      end else begin
        dq_d = {dq_q[OperW-2:0], ge};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      root_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      root_q <= root_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    res_q <= res_d;
    den_q <= den_d;
  end

  assign sts_o.busy = busy_q;
  assign quot_o     = dq_q;
  assign root_o     = res_q;

endmodule

`default_nettype wire

@@ hw/rtl/online_exponential_cmvn_unit.sv @@
// ----------------------------------------------------------------------------
// Online exponential CMVN unit
// Per-dimension running mean/variance normalization in Q16.16.
// ----------------------------------------------------------------------------
// A sample is processed in turn by two divisions by ten of 7 shift-and-add steps
// each, a 24-step root and a 51-step division in the shared step unit, with
// sequencing states between them. A load, a no-op, a flagged index or a start
// that copies nothing goes straight to output; a start that copies reads and
// writes the first min(vec_size,64) entries in turn. One transaction at a time.
// Reset clears all statistics through valid bits; vec_size 39, reset_mode 2.
`default_nettype none

module online_exponential_cmvn_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [71:0] s_axis_tdata,  // dim_index, sample_value, init_variance, zero pad
  input  wire  [1:0]  s_axis_tuser,  // opcode
  input  wire         s_axis_tlast,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,  // normalized_value, dim_index_out, zero pad
  output logic [1:0]  m_axis_tuser,  // status
  output logic        m_axis_tlast,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_addr_i,
  input  wire  [7:0]  cfg_data_i
);
  import ocmvn_pkg::*;

  state_e state_q, state_d;

  logic [6:0] vec_size_q;
  mode_e      mode_q;
  logic       consumed_q;

  logic [DimMax-1:0] run_vld_q, init_vld_q;
  logic              rvld_q, ivld_q;

  logic [DimW-1:0] idx_q;
  logic            last_q;
  logic [31:0]     x_q;
  logic [31:0]     m_q, v_q, nv_q, nm_q, y_q;
  logic [32:0]     d_q;
  logic [63:0]     sq_q;
  logic            sat_q;
  status_e         stat_q;
  logic [DimW-1:0] cp_q;
  logic [48:0]     tn_q, tq_q, tr_q;
  logic [2:0]      ph_q;

  logic            run_we, init_we;
  logic [DimW-1:0] run_waddr, run_raddr, init_raddr;
  logic [EntryW-1:0] run_wdata, run_rdata, init_rdata;

  step_cmd_t  cmd;
  step_sts_t  sts;
  logic [OperW-1:0] quot;
  logic [RootW-1:0] root;

  logic       in_acc, in_range, copy_now;
  logic [6:0] n_act;
  logic [DimW-1:0] in_idx;
  op_e        in_op;

  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign in_idx   = s_axis_tdata[DimW-1:0];
  assign in_op    = op_e'(s_axis_tuser);
  assign in_range = {1'b0, in_idx} < vec_size_q;
  assign n_act    = (vec_size_q > 7'(DimMax)) ? 7'(DimMax) : vec_size_q;
  assign copy_now = ((mode_q == MODE_EVERY) || (mode_q == MODE_ONCE && !consumed_q))
                    && (n_act != 7'd0);
  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);

  // Datapath helpers.
  logic [31:0] dmag;
  logic [48:0] var_num;
  logic [32:0] mean_num, nm_wide;
  logic [32:0] diff;
  logic [31:0] diff_mag;
  logic [DenW-1:0] den;
  logic [OperW-1:0] norm_num;
  logic [48:0] sqf;
  logic [48:0] tq_d;

  always_comb begin
    dmag     = d_q[32] ? 32'(-d_q) : d_q[31:0];
    sqf      = {1'b0, sq_q[63:16]} + {48'd0, sq_q[15]};
    var_num  = {14'd0, v_q, 3'b000} + {17'd0, v_q} + sqf + 49'd5;
    mean_num = {1'b0, dmag} + 33'd5;
    nm_wide  = d_q[32] ? ({m_q[31], m_q} - tq_q[32:0]) : ({m_q[31], m_q} + tq_q[32:0]);
    diff     = {x_q[31], x_q} - {nm_q[31], nm_q};
    diff_mag = diff[32] ? 32'(-diff) : diff[31:0];
    den      = {1'b0, root} + DenW'(32'h10000);
    norm_num = {1'b0, diff_mag, 18'd0} + {27'd0, den[DenW-1:1]};
  end

  // Division by ten: an estimate of n*0.8 built by shifts and adds, scaled by
  // one eighth, then corrected once by the remainder.
  always_comb begin
    case (ph_q)
      3'd0:    tq_d = (tn_q >> 1) + (tn_q >> 2);
      3'd1:    tq_d = tq_q + (tq_q >> 4);
      3'd2:    tq_d = tq_q + (tq_q >> 8);
      3'd3:    tq_d = tq_q + (tq_q >> 16);
      3'd4:    tq_d = (tq_q + (tq_q >> 32)) >> 3;
      3'd6:    tq_d = tq_q + {48'd0, tr_q > 49'd9};
      default: tq_d = tq_q;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_SAMPLE && in_range) state_d = S_RD;
          else if (in_op == OP_START && copy_now) state_d = S_CP_RD;
          else state_d = S_OUT;
        end
      end
      S_RD:    state_d = S_MUL;
      S_MUL:   state_d = S_VAR;
      S_VAR:   state_d = S_DIVV;
      S_DIVV:  if (ph_q == TenthLastPh) state_d = S_MEAN;
      S_MEAN:  state_d = S_DIVM;
      S_DIVM:  if (ph_q == TenthLastPh) state_d = S_UPD;
      S_UPD:   state_d = S_SQRT;
      S_SQRT:  if (!sts.busy) state_d = S_DEN;
      S_DEN:   state_d = S_DIVQ;
      S_DIVQ:  if (!sts.busy) state_d = S_FIN;
      S_FIN:   state_d = S_OUT;
      S_CP_RD: state_d = S_CP_WR;
      S_CP_WR: if ({1'b0, cp_q} + 7'd1 == n_act) state_d = S_OUT; else state_d = S_CP_RD;
      S_OUT:   if (!m_axis_tvalid || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    cmd        = '0;
    run_we     = 1'b0;
    run_waddr  = idx_q;
    run_wdata  = {nm_wide[31:0], nv_q};
    run_raddr  = in_idx;
    init_raddr = cp_q;
    init_we    = in_acc && in_op == OP_LOAD && in_range;
    case (state_q)
      S_UPD: begin
        run_we      = 1'b1;
        cmd.start   = 1'b1;
        cmd.root    = 1'b1;
        cmd.steps   = StepsRoot;
        cmd.operand = {nv_q, 19'd0};
      end
      S_DEN: begin
        cmd.start   = 1'b1;
        cmd.steps   = StepsNorm;
        cmd.operand = norm_num;
        cmd.divisor = den;
      end
      S_CP_WR: begin
        run_we    = 1'b1;
        run_waddr = cp_q;
        run_wdata = ivld_q ? init_rdata : '0;
      end
      default: ;
    endcase
  end

  ocmvn_ram #(.Width(EntryW), .Depth(DimMax)) u_run_ram (
    .clk_i   (clk_i),
    .we_i    (run_we),
    .waddr_i (run_waddr),
    .wdata_i (run_wdata),
    .raddr_i (run_raddr),
    .rdata_o (run_rdata)
  );

  ocmvn_ram #(.Width(EntryW), .Depth(DimMax)) u_init_ram (
    .clk_i   (clk_i),
    .we_i    (init_we),
    .waddr_i (in_idx),
    .wdata_i ({s_axis_tdata[37:6], s_axis_tdata[69:38]}),
    .raddr_i (init_raddr),
    .rdata_o (init_rdata)
  );

  ocmvn_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .quot_o (quot),
    .root_o (root)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      vec_size_q    <= 7'd39;
      mode_q        <= MODE_EVERY;
      consumed_q    <= 1'b0;
      run_vld_q     <= '0;
      init_vld_q    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (reg_e'(cfg_addr_i) == REG_VEC_SIZE) vec_size_q <= cfg_data_i[6:0];
        else if (reg_e'(cfg_addr_i) == REG_RESET_MODE) mode_q <= mode_e'(cfg_data_i[1:0]);
      end
      if (in_acc && in_op == OP_START && mode_q == MODE_ONCE) consumed_q <= 1'b1;
      if (init_we) init_vld_q[in_idx] <= 1'b1;
      if (run_we) run_vld_q[run_waddr] <= 1'b1;
      if (state_q == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      idx_q  <= in_idx;
      last_q <= s_axis_tlast;
      x_q    <= s_axis_tdata[37:6];
      rvld_q <= run_vld_q[in_idx];
      sat_q  <= 1'b0;
      y_q    <= '0;
      cp_q   <= '0;
      stat_q <= ((in_op == OP_SAMPLE || in_op == OP_LOAD) && !in_range) ? ST_RANGE : ST_OK;
    end
    case (state_q)
      S_RD: begin
        m_q <= rvld_q ? run_rdata[63:32] : '0;
        v_q <= rvld_q ? run_rdata[31:0] : '0;
        d_q <= {x_q[31], x_q} - (rvld_q ? {run_rdata[63], run_rdata[63:32]} : 33'd0);
      end
      S_MUL: sq_q <= dmag * dmag;
      S_VAR: begin
        tn_q <= var_num;
        ph_q <= '0;
      end
      S_DIVV, S_DIVM: begin
        tq_q <= tq_d;
        tr_q <= tn_q - ((tq_q << 3) + (tq_q << 1));
        ph_q <= ph_q + 1'b1;
      end
      S_MEAN: begin
        if (tq_q[48:32] != '0) begin
          nv_q  <= '1;
          sat_q <= 1'b1;
        end else begin
          nv_q <= tq_q[31:0];
        end
        tn_q <= {16'd0, mean_num};
        ph_q <= '0;
      end
      S_UPD: nm_q <= nm_wide[31:0];
      S_FIN: begin
        if (diff[32]) begin
          if (quot > OperW'(33'h80000000)) begin
            y_q   <= 32'h80000000;
            sat_q <= 1'b1;
          end else begin
            y_q <= 32'(-quot[31:0]);
          end
        end else begin
          if (quot > OperW'(32'h7FFFFFFF)) begin
            y_q   <= 32'h7FFFFFFF;
            sat_q <= 1'b1;
          end else begin
            y_q <= quot[31:0];
          end
        end
      end
      S_CP_RD: ivld_q <= init_vld_q[cp_q];
      S_CP_WR: cp_q <= cp_q + 1'b1;
      default: ;
    endcase
    if (state_q == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {2'b00, idx_q, y_q};
      m_axis_tuser <= (stat_q == ST_OK && sat_q) ? ST_SAT : stat_q;
      m_axis_tlast <= last_q;
    end
  end

`ifndef SYNTHESIS
  a_step_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |-> !sts.busy) else $error("step unit started while busy");
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !run_we) else $error("running stats written while idle");
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready) else $error("second transaction taken too early");
`endif

endmodule

`default_nettype wire
